// ===== hw/rtl/tag_uid_dedup_filter_macros.svh =====
// Assertion macros used by the tag UID dedup filter top level.
`ifndef TAG_UID_DEDUP_FILTER_MACROS_SVH
`define TAG_UID_DEDUP_FILTER_MACROS_SVH

`ifndef SYNTHESIS
// Checked at every rising clock edge, masked while reset is asserted.
`define TUDF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tag_uid_dedup_filter assertion failed");
// Checked at every rising clock edge, also during reset.
`define TUDF_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tag_uid_dedup_filter assertion failed");
`else
`define TUDF_ASSERT(lbl, prop)
`define TUDF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/tudf_pkg.sv =====
// Types and constants of the tag UID dedup filter.
package tudf_pkg;

	localparam int KEY_W      = 56;
	localparam int LEN_W      = 4;
	localparam int FIELD_BYTES = KEY_W / 8;
	// longest UID in bytes; reported lengths above it clamp to it
	localparam int UID_BYTES  = 7;

	typedef struct packed {
		logic              command;
		logic [KEY_W-1:0]  uid;
		logic [LEN_W-1:0]  uid_len;
		logic [31:0]       time_ms;
	} tudf_req_t;

	typedef struct packed {
		logic              repeat_res;
		logic              stored;
		logic [31:0]       scan_total;
		logic [31:0]       unique_total;
		logic [3:0]        entries_in_use;
		logic [31:0]       update_number;
		logic [KEY_W-1:0]  latest_uid;
		logic [2:0]        last_len;
		logic [31:0]       last_time;
	} tudf_rsp_t;

	// Search token walking down the cell row.
	typedef struct packed {
		logic              vld;
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  len;
		logic              hit;
	} tudf_tok_t;

	// Entry write broadcast from the controller.
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [LEN_W-1:0]  len;
	} tudf_wr_t;

endpackage

// ===== hw/rtl/tag_uid_dedup_filter.sv =====
// Top level of the tag UID dedup filter: controller, counters and cell row.
//
//  channel | dir | handshake             | beat
//  --------+-----+-----------------------+--------------------------------------
//  req     | in  | req_valid / req_ready | one card read report or clear command
//  rsp     | out | rsp_valid / rsp_ready | status after that item
//
// Flow: an item enters from S_IDLE, its search token then walks the cell
// row register by register, and the item commits in S_COMMIT.
// Stalls: a held rsp beat stalls the commit only; the next request is taken
// as soon as the commit has happened, while the response still waits.
// Reset: counters, last-read fields and fill count clear at once; table
// entries are not cleared and are never read above the fill count.
`include "tag_uid_dedup_filter_macros.svh"

module tag_uid_dedup_filter #(
	parameter int CAPACITY  = 10
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  tudf_pkg::tudf_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output tudf_pkg::tudf_rsp_t rsp
);
	import tudf_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(UID_BYTES);
	localparam logic [FW-1:0]    CapVal = FW'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_COMMIT
	} state_t;

	state_t           state_q;
	logic [FW-1:0]    fill_q;
	logic [31:0]      scan_q;
	logic [31:0]      uniq_q;
	logic [31:0]      seq_q;
	logic [KEY_W-1:0] recent_id_q;
	logic [LEN_W-1:0] recent_len_q;
	logic [31:0]      recent_time_q;
	logic             rsp_valid_q;
	tudf_rsp_t        rsp_q;

	// item held while its token walks
	logic             cmd_q;
	logic             nocard_q;
	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic [31:0]      time_q;
	logic             hit_q;

	logic             accept;
	logic [LEN_W-1:0] len_c;
	logic [KEY_W-1:0] key_c;
	tudf_tok_t        tok [CAPACITY+1];
	logic [CAPACITY-1:0] chain_vld;
	logic             commit;
	logic             do_store;
	tudf_wr_t         wr;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// clamp the length and zero the bytes beyond it
	assign len_c = (req.uid_len > MaxLen) ? MaxLen : req.uid_len;
	always_comb begin
		for (int b = 0; b < FIELD_BYTES; b++) begin
			key_c[8*b +: 8] = (LEN_W'(b) < len_c) ? req.uid[8*b +: 8] : 8'h00;
		end
	end

	always_comb begin
		tok[0].vld = accept;
		tok[0].key = key_c;
		tok[0].len = len_c;
		tok[0].hit = 1'b0;
	end

	assign commit   = (state_q == S_COMMIT) && (!rsp_valid_q || rsp_ready);
	assign do_store = !cmd_q && !nocard_q && !hit_q && (fill_q < CapVal);
	assign wr.key   = key_q;
	assign wr.len   = len_q;

	// cell row: one entry per cell, the token moves one cell a cycle
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic live;
		logic wr_en;

		assign live  = (FW'(i) < fill_q);
		assign wr_en = commit && do_store && (fill_q == FW'(i));
		assign chain_vld[i] = tok[i+1].vld;

		tudf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.live    (live),
			.wr_en   (wr_en),
			.wr      (wr),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1])
		);
	end

	// payload of the item in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= req.command;
			nocard_q <= (req.uid_len == '0);
			key_q    <= key_c;
			len_q    <= len_c;
			time_q   <= req.time_ms;
		end
		if (tok[CAPACITY].vld) begin
			hit_q <= tok[CAPACITY].hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			scan_q        <= '0;
			uniq_q        <= '0;
			seq_q         <= '0;
			recent_id_q   <= '0;
			recent_len_q  <= '0;
			recent_time_q <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			// raise the response on commit, drop it once taken
			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (tok[CAPACITY].vld) begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					if (commit) begin
						state_q     <= S_IDLE;
						priority if (cmd_q) begin
							// clear: drop the table, zero counters, bump sequence
							fill_q        <= '0;
							scan_q        <= '0;
							uniq_q        <= '0;
							seq_q         <= seq_q + 32'd1;
							recent_id_q   <= '0;
							recent_len_q  <= '0;
							recent_time_q <= '0;
							rsp_q.repeat_res     <= 1'b0;
							rsp_q.stored         <= 1'b0;
							rsp_q.scan_total     <= '0;
							rsp_q.unique_total   <= '0;
							rsp_q.entries_in_use <= '0;
							rsp_q.update_number  <= seq_q + 32'd1;
							rsp_q.latest_uid     <= '0;
							rsp_q.last_len       <= '0;
							rsp_q.last_time      <= '0;
						end else if (nocard_q) begin
							// no card: report the current state unchanged
							rsp_q.repeat_res     <= 1'b0;
							rsp_q.stored         <= 1'b0;
							rsp_q.scan_total     <= scan_q;
							rsp_q.unique_total   <= uniq_q;
							rsp_q.entries_in_use <= 4'(fill_q);
							rsp_q.update_number  <= seq_q;
							rsp_q.latest_uid     <= recent_id_q;
							rsp_q.last_len       <= recent_len_q[2:0];
							rsp_q.last_time      <= recent_time_q;
						end else begin
							fill_q        <= fill_q + FW'(do_store);
							scan_q        <= scan_q + 32'd1;
							uniq_q        <= uniq_q + 32'(!hit_q);
							seq_q         <= seq_q + 32'd1;
							recent_id_q   <= key_q;
							recent_len_q  <= len_q;
							recent_time_q <= time_q;
							rsp_q.repeat_res     <= hit_q;
							rsp_q.stored         <= do_store;
							rsp_q.scan_total     <= scan_q + 32'd1;
							rsp_q.unique_total   <= uniq_q + 32'(!hit_q);
							rsp_q.entries_in_use <= 4'(fill_q + FW'(do_store));
							rsp_q.update_number  <= seq_q + 32'd1;
							rsp_q.latest_uid     <= key_q;
							rsp_q.last_len       <= len_q[2:0];
							rsp_q.last_time      <= time_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// at most one search token in the row
	`TUDF_ASSERT(a_one_token, $onehot0(chain_vld))
	// the token leaves the row only while the controller waits for it
	`TUDF_ASSERT(a_tail_in_walk, tok[CAPACITY].vld |-> state_q == S_WALK)
	// fill count never passes the table size
	`TUDF_ASSERT(a_fill_bound, fill_q <= CapVal)
	// a repeat is never stored again
	`TUDF_ASSERT(a_rep_not_stored, rsp_valid_q |-> !(rsp_q.repeat_res && rsp_q.stored))
	// an accepted beat closes the request side until its commit
	`TUDF_ASSERT(a_one_in_flight, accept |=> !req_ready)

endmodule

// ===== hw/rtl/tudf_cell.sv =====
// One table entry: holds a stored UID and compares the passing token against it.
module tudf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               live,
	input  logic               wr_en,
	input  tudf_pkg::tudf_wr_t wr,
	input  tudf_pkg::tudf_tok_t tok_in,
	output tudf_pkg::tudf_tok_t tok_out
);
	import tudf_pkg::*;

	logic [KEY_W-1:0] key_q;
	logic [LEN_W-1:0] len_q;
	logic             vld_s1;
	tudf_tok_t        pay_s1;
	logic             match;

	assign match = live && (len_q == tok_in.len) && (key_q == tok_in.key);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q <= wr.key;
			len_q <= wr.len;
		end
	end

	// advance the token one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		pay_s1.vld <= 1'b0;
		pay_s1.key <= tok_in.key;
		pay_s1.len <= tok_in.len;
		pay_s1.hit <= tok_in.hit | (tok_in.vld & match);
	end

	always_comb begin
		tok_out     = pay_s1;
		tok_out.vld = vld_s1;
	end

endmodule
